// File: rtl/core/rthc_pkg.sv
// ----------------------------------------------------------------------------
// rthc_pkg
// Shared types and constants for the RGB to HSV converter: the pixel and
// HSV request structs, and the codes for the hue sector.
// ----------------------------------------------------------------------------
package rthc_pkg;

  // channel and hue field widths
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;

  // hue sector, picked by the largest channel
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

endpackage

// File: rtl/core/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts one 8-bit RGB pixel to hue, saturation and value. Pipelined, one
// pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The converter takes one pixel request per clock unless the output stalls,
// and returns one HSV request per pixel, in order. With QW the larger of 8
// and HUE_FRAC_BITS + 6, the stages run as follows: one stage
// finds max, min and the hue sector, one forms the two dividends, QW stages
// run two radix-2 restoring dividers side by side (one quotient bit per stage
// for hue and for saturation) and the last stage assembles the result into
// the output register. Hue is in units of 1/2^HUE_FRAC_BITS degree and is
// masked to 15 bits; saturation is (max-min)*255/max truncated; brightness is
// the largest channel. A grey pixel gives hue and saturation of zero. Each
// stage moves on when the one after it is empty or moving, so bubbles fill
// and a stalled output holds without loss.
module rgb_to_hsv_converter
  import rthc_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_stall,
  output hsv_t   hsv
);

  // quotient bits per divider, dividend width, last stage index
  localparam int QW  = (HUE_FRAC_BITS + 6 > CHAN_W) ? HUE_FRAC_BITS + 6 : CHAN_W;
  localparam int NW  = CHAN_W + QW;
  localparam int L   = QW + 1;
  localparam int HSW = HUE_FRAC_BITS + 16;

  localparam logic [NW-1:0]         HUE_SIXTH  = NW'(60) << HUE_FRAC_BITS;
  localparam logic signed [HSW-1:0] HUE_THIRD  = HSW'(120) << HUE_FRAC_BITS;
  localparam logic signed [HSW-1:0] HUE_2THIRD = HSW'(240) << HUE_FRAC_BITS;
  localparam logic signed [HSW-1:0] HUE_FULL   = HSW'(360) << HUE_FRAC_BITS;

  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] delta;
    logic [1:0]        sector;
    logic              neg;
    logic [CHAN_W-1:0] adiff;
    logic [NW-1:0]     hw;
    logic [NW-1:0]     sw;
  } stage_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] w,
                                             input logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] t;
    logic            ge;
    logic [CHAN_W:0] r;
    t  = {w[NW-1:QW], w[QW-1]};
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {r[CHAN_W-1:0], w[QW-2:0], ge};
  endfunction

  stage_t      st  [0:L];
  logic [L:0]  vld;
  logic [L+1:0] rdy;

  // ready chain from the output register back to the input
  assign rdy[L+1] = !hsv_valid || !hsv_stall;
  for (genvar k = 0; k <= L; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign pixel_stall = !rdy[0];

  // front: max, min, sector and signed channel difference
  logic [CHAN_W-1:0] mx, mn, da, db, adiff;
  logic [1:0]        sector;
  logic              neg;
  always_comb begin
    mx = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    if (pixel.red >= mx) begin
      sector = SECT_RED;
      da     = pixel.green;
      db     = pixel.blue;
    end else if (pixel.green >= mx) begin
      sector = SECT_GREEN;
      da     = pixel.blue;
      db     = pixel.red;
    end else begin
      sector = SECT_BLUE;
      da     = pixel.red;
      db     = pixel.green;
    end
    neg   = (da < db);
    adiff = neg ? (db - da) : (da - db);
  end

  // stage 0: front results
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= pixel_valid;
    end
    if (rdy[0]) begin
      st[0].mx     <= mx;
      st[0].delta  <= mx - mn;
      st[0].sector <= sector;
      st[0].neg    <= neg;
      st[0].adiff  <= adiff;
      st[0].hw     <= '0;
      st[0].sw     <= '0;
    end
  end

  // stage 1: dividends, 60*2^F*|diff| for hue and delta*255 for saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (rdy[1]) begin
      vld[1] <= vld[0];
    end
    if (rdy[1]) begin
      st[1].mx     <= st[0].mx;
      st[1].delta  <= st[0].delta;
      st[1].sector <= st[0].sector;
      st[1].neg    <= st[0].neg;
      st[1].adiff  <= st[0].adiff;
      st[1].hw     <= NW'(st[0].adiff) * HUE_SIXTH;
      st[1].sw     <= (NW'(st[0].delta) << CHAN_W) - NW'(st[0].delta);
    end
  end

  // divider stages, one quotient bit each for hue and saturation
  for (genvar k = 2; k <= L; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
      if (rdy[k]) begin
        st[k].mx     <= st[k-1].mx;
        st[k].delta  <= st[k-1].delta;
        st[k].sector <= st[k-1].sector;
        st[k].neg    <= st[k-1].neg;
        st[k].adiff  <= st[k-1].adiff;
        st[k].hw     <= div_step(st[k-1].hw, st[k-1].delta);
        st[k].sw     <= div_step(st[k-1].sw, st[k-1].mx);
      end
    end
  end

  // result assembly: sector offset, sign, wrap, grey override
  logic signed [HSW-1:0] hq, hsig, hoff, hsum;
  hsv_t                  res;
  always_comb begin
    hq   = signed'(HSW'(st[L].hw[QW-1:0]));
    hsig = st[L].neg ? -hq : hq;
    unique case (st[L].sector)
      SECT_RED:   hoff = '0;
      SECT_GREEN: hoff = HUE_THIRD;
      SECT_BLUE:  hoff = HUE_2THIRD;
      default:    hoff = '0;
    endcase
    hsum = hoff + hsig;
    if (hsum[HSW-1]) hsum = hsum + HUE_FULL;
    res.brightness = st[L].mx;
    if (st[L].delta == '0) begin
      res.hue        = '0;
      res.saturation = '0;
    end else begin
      res.hue        = hsum[HUE_W-1:0];
      res.saturation = st[L].sw[CHAN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (rdy[L+1]) begin
      hsv_valid <= vld[L];
    end
    if (rdy[L+1]) begin
      hsv <= res;
    end
  end

  // zero saturation only for grey pixels, which carry zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("zero saturation with nonzero hue");

  // hue stays below a full turn when it fits the field
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (HUE_FRAC_BITS > 6) || (hsv.hue < HUE_FULL[HUE_W-1:0]))
    else $error("hue out of range");

  // an empty output register lets the whole pipe take a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !hsv_valid |-> !pixel_stall)
    else $error("input stalled with output register empty");

  // an accepted request lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> vld[0])
    else $error("accepted request lost at entry");

endmodule

// File: bench/rgb_to_hsv_converter_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking bench for the RGB to HSV converter. Pixel requests go in
// through a directed set (greys, primaries, tied maxima, hue wrap), a long
// random stream and an output hold-off that fills the pipeline. Every HSV
// request is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb
  import rthc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // hue scale at the default fraction width
  localparam int FRAC_BITS   = 6;
  localparam int HUE_SIXTH   = 60 << FRAC_BITS;
  localparam int HUE_THIRD   = 120 << FRAC_BITS;
  localparam int HUE_2THIRD  = 240 << FRAC_BITS;
  localparam int HUE_FULL    = 360 << FRAC_BITS;
  localparam int PIPE_DEPTH  = 18;
  localparam int HOLD_CYCLES = 90;
  localparam int STALL_LIMIT = 3000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel = '0;
  logic   hsv_valid;
  logic   hsv_stall = 1'b0;
  hsv_t   hsv;

  hsv_t hsv_expected[$];
  hsv_t hsv_want;
  int   errors = 0;
  int   idle_pct = 11;
  int   stall_pct = 11;
  bit   hold_request = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  rgb_to_hsv_converter uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected hsv for one pixel
  function automatic hsv_t hsv_of_pixel(input pixel_t p);
    int r, g, b, top, bottom, delta, hue_val, sat_val;
    logic [1:0] sector;
    hsv_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    delta = top - bottom;
    hue_val = 0;
    sat_val = 0;
    if (delta != 0) begin
      sat_val = (delta * 255) / top;
      // ties go to red, then green
      if (r >= top) sector = SECT_RED;
      else if (g >= top) sector = SECT_GREEN;
      else sector = SECT_BLUE;
      case (sector)
        SECT_RED:   hue_val = (HUE_SIXTH * (g - b)) / delta;
        SECT_GREEN: hue_val = HUE_THIRD + (HUE_SIXTH * (b - r)) / delta;
        default:    hue_val = HUE_2THIRD + (HUE_SIXTH * (r - g)) / delta;
      endcase
      if (hue_val < 0) hue_val += HUE_FULL;
    end
    res.hue        = HUE_W'(hue_val);
    res.saturation = CHAN_W'(sat_val);
    res.brightness = CHAN_W'(top);
    return res;
  endfunction

  function automatic pixel_t mk_pixel(input int r, input int g, input int b);
    pixel_t p;
    p.red   = CHAN_W'(r);
    p.green = CHAN_W'(g);
    p.blue  = CHAN_W'(b);
    return p;
  endfunction

  // pixel with a bias toward greys, ties, extremes and narrow spreads
  function automatic pixel_t random_pixel();
    int kind, r, g, b, sel, spread;
    kind = $urandom_range(99);
    r = $urandom_range(255);
    g = $urandom_range(255);
    b = $urandom_range(255);
    if (kind < 10) begin
      g = r;
      b = r;
    end else if (kind < 28) begin
      sel = $urandom_range(2);
      if (sel == 0) g = r;
      else if (sel == 1) b = g;
      else b = r;
    end else if (kind < 38) begin
      r = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
      g = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
      b = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
    end else if (kind < 50) begin
      spread = $urandom_range(3);
      g = r + $urandom_range(2 * spread) - spread;
      b = r + $urandom_range(2 * spread) - spread;
      if (g < 0) g = 0;
      if (g > 255) g = 255;
      if (b < 0) b = 0;
      if (b > 255) b = 255;
    end
    return mk_pixel(r, g, b);
  endfunction

  // offer one pixel request, wait for the handshake, queue its result
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    hsv_expected.push_back(hsv_of_pixel(p));
  endtask

  // output side stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_request != hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = hold_request;
    end
    if (hold_left > 0) begin
      hsv_stall <= 1'b1;
      hold_left--;
    end else begin
      hsv_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && hsv_valid && !hsv_stall) begin
      if (hsv_expected.size() == 0) begin
        $display("%0t: unexpected hsv request hue=%0d sat=%0d val=%0d",
                 $realtime, hsv.hue, hsv.saturation, hsv.brightness);
        errors++;
      end else begin
        hsv_want = hsv_expected.pop_front();
        if (hsv.hue !== hsv_want.hue) begin
          $display("%0t: hue expected %0d got %0d", $realtime, hsv_want.hue, hsv.hue);
          errors++;
        end
        if (hsv.saturation !== hsv_want.saturation) begin
          $display("%0t: saturation expected %0d got %0d", $realtime,
                   hsv_want.saturation, hsv.saturation);
          errors++;
        end
        if (hsv.brightness !== hsv_want.brightness) begin
          $display("%0t: brightness expected %0d got %0d", $realtime,
                   hsv_want.brightness, hsv.brightness);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // greys, primaries, tied maxima, truncation and hue wrap
  task automatic test_directed();
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(128, 128, 128));
    send_pixel(mk_pixel(1, 1, 1));
    send_pixel(mk_pixel(255, 0, 0));
    send_pixel(mk_pixel(0, 255, 0));
    send_pixel(mk_pixel(0, 0, 255));
    send_pixel(mk_pixel(255, 255, 0));
    send_pixel(mk_pixel(0, 255, 255));
    send_pixel(mk_pixel(255, 0, 255));
    send_pixel(mk_pixel(200, 200, 10));
    send_pixel(mk_pixel(10, 200, 200));
    send_pixel(mk_pixel(200, 10, 200));
    send_pixel(mk_pixel(255, 0, 1));
    send_pixel(mk_pixel(1, 0, 0));
    send_pixel(mk_pixel(0, 0, 1));
    send_pixel(mk_pixel(255, 128, 0));
    send_pixel(mk_pixel(254, 255, 253));
    send_pixel(mk_pixel(170, 85, 255));
    send_pixel(mk_pixel(3, 2, 1));
  endtask

  // random stream, first part with no idling on either side
  task automatic test_random_stream(input int count);
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 5) begin
        idle_pct = 11;
        stall_pct = 11;
      end
      send_pixel(random_pixel());
    end
  endtask

  // long output hold-off while pixels keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    hold_request = !hold_request;
    for (int i = 0; i < 48; i++) send_pixel(random_pixel());
    idle_pct = 11;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream(600);
    test_backpressure();
    test_random_stream(40);
    pixel_valid <= 1'b0;
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
